// ===== rtl/core/cbrf_pkg.sv =====
package cbrf_pkg;

	localparam int unsigned BYTE_BITS     = 8;
	localparam int unsigned PORT_ADDR_BITS = 48;
	localparam int unsigned LEN_BITS      = 32;
	localparam int unsigned GAP_BITS      = 8;

	localparam logic [GAP_BITS-1:0] MAX_GAP_RESET = 8'd32;
	localparam logic [LEN_BITS-1:0] LEN_SAT       = '1;

	typedef struct packed {
		logic [BYTE_BITS-1:0]      old_byte;
		logic [BYTE_BITS-1:0]      new_byte;
		logic [PORT_ADDR_BITS-1:0] byte_address;
		logic                      range_end;
	} byte_pair_t;

	typedef struct packed {
		logic [PORT_ADDR_BITS-1:0] run_start;
		logic [LEN_BITS-1:0]       run_length;
	} run_t;

endpackage

// ===== rtl/core/cbrf_tracker.sv =====
module cbrf_tracker #(
	parameter int unsigned ADDR_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [cbrf_pkg::GAP_BITS-1:0]    max_gap,
	input  logic                             step,
	input  cbrf_pkg::byte_pair_t             pair,
	output logic                             emit,
	output cbrf_pkg::run_t                   run
);

	localparam int unsigned EXT_BITS = 65;

	logic                 run_open_q;
	logic [ADDR_BITS-1:0] open_start_q;
	logic [ADDR_BITS-1:0] last_change_q;

	logic                 differs;
	logic [ADDR_BITS-1:0] addr;
	logic [ADDR_BITS-1:0] gap;
	logic                 gap_close;
	logic                 open_n;
	logic [ADDR_BITS-1:0] start_n;
	logic [ADDR_BITS-1:0] last_n;
	logic [ADDR_BITS-1:0] diff;
	logic [EXT_BITS-1:0]  diff_ext;

	assign differs   = pair.old_byte != pair.new_byte;
	assign addr      = ADDR_BITS'(pair.byte_address);
	assign gap       = addr - last_change_q;
	assign gap_close = !differs && run_open_q && (gap > ADDR_BITS'(max_gap));

	always_comb begin
		open_n  = run_open_q;
		start_n = open_start_q;
		last_n  = last_change_q;
		if (differs) begin
			open_n = 1'b1;
			last_n = addr;
			if (!run_open_q) begin
				start_n = addr;
			end
		end
	end

	assign emit     = gap_close || (pair.range_end && open_n);
	assign diff     = last_n - start_n;
	assign diff_ext = EXT_BITS'(diff);

	always_comb begin
		run.run_start = cbrf_pkg::PORT_ADDR_BITS'(start_n);
		if (diff_ext >= EXT_BITS'(cbrf_pkg::LEN_SAT)) begin
			run.run_length = cbrf_pkg::LEN_SAT;
		end else begin
			run.run_length = diff_ext[cbrf_pkg::LEN_BITS-1:0] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q    <= 1'b0;
			open_start_q  <= '0;
			last_change_q <= '0;
		end else if (step) begin
			run_open_q    <= open_n && !emit;
			open_start_q  <= start_n;
			last_change_q <= last_n;
		end
	end

	// every step that emits leaves no run open
	assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> !run_open_q)
		else $error("run still open after emit");

	// a changed byte that does not end the range always leaves a run open
	assert property (@(posedge clk) disable iff (!arst_n)
		step && differs && !pair.range_end |=> run_open_q)
		else $error("changed byte left no open run");

	// a changed byte never closes a run by gap
	assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && !pair.range_end |-> !differs && run_open_q)
		else $error("emit without gap close");

	// an emitted run has a length of at least one
	assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |-> run.run_length != '0)
		else $error("zero run length");

endmodule

// ===== rtl/core/cbrf_out_stage.sv =====
module cbrf_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  cbrf_pkg::run_t run_d,
	output logic           free,
	output logic           out_valid,
	input  logic           out_ready,
	output cbrf_pkg::run_t run_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run_d;
		end
	end

endmodule

// ===== rtl/core/changed_byte_run_finder.sv =====
// changed_byte_run_finder
// finds runs of changed bytes in a stream of old/new byte pairs
// input channel: in_valid/in_ready, one byte pair per beat with its address
//   and a flag marking the last byte of the range
// output channel: out_valid/out_ready, one beat per closed run carrying
//   run_start and run_length (saturating at all ones)
// config channel: cfg_valid/cfg_ready writes max_gap (reset value 32);
//   cfg_ready is always high, write only while the block is idle
// path: a run closed by an input beat goes through the input register, then
//   the result register, and may wait in the input register behind a held result
// throughput: one input beat per cycle unless a closing beat waits behind a
//   held result; the run update between the two registers is combinational
// stall: a held result keeps its beat; the input register still takes and
//   retires beats that close nothing, and in_ready drops only when a beat
//   that closes a run waits behind a held result
// reset: no run open, both registers empty, max_gap back to 32
module changed_byte_run_finder #(
	parameter int unsigned ADDR_BITS = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cbrf_pkg::BYTE_BITS-1:0]        old_byte,
	input  logic [cbrf_pkg::BYTE_BITS-1:0]        new_byte,
	input  logic [cbrf_pkg::PORT_ADDR_BITS-1:0]   byte_address,
	input  logic                                  range_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cbrf_pkg::PORT_ADDR_BITS-1:0]   run_start,
	output logic [cbrf_pkg::LEN_BITS-1:0]         run_length,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cbrf_pkg::GAP_BITS-1:0]         cfg_data
);

	logic [cbrf_pkg::GAP_BITS-1:0] max_gap_q;
	logic                          valid_s1;
	cbrf_pkg::byte_pair_t          pair_s1;

	logic           emit;
	logic           free;
	logic           step;
	cbrf_pkg::run_t run_d;
	cbrf_pkg::run_t run_q;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && (!emit || free);
	assign in_ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= cbrf_pkg::MAX_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pair_s1.old_byte     <= old_byte;
			pair_s1.new_byte     <= new_byte;
			pair_s1.byte_address <= byte_address;
			pair_s1.range_end    <= range_end;
		end
	end

	cbrf_tracker #(
		.ADDR_BITS(ADDR_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.max_gap(max_gap_q),
		.step   (step),
		.pair   (pair_s1),
		.emit   (emit),
		.run    (run_d)
	);

	cbrf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && emit),
		.run_d    (run_d),
		.free     (free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.run_q    (run_q)
	);

	assign run_start  = run_q.run_start;
	assign run_length = run_q.run_length;

endmodule
